[sv/ecf_pkg.sv]
// ----------------------------------------------------------------------------
// ecf_pkg
// Shared types and constants of the Eulerian circuit finder.
// ----------------------------------------------------------------------------
package ecf_pkg;

	localparam int NODE_W = 5;
	localparam int STAT_W = 2;

	localparam int DEF_MAX_NODES  = 16;
	localparam int DEF_MAX_DEGREE = 4;
	localparam int DEF_MAX_EDGES  = 32;

	localparam logic [NODE_W-1:0] DEF_NODE_COUNT = 5'd16;

	localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
	localparam logic [STAT_W-1:0] ST_DISC  = 2'd1;
	localparam logic [STAT_W-1:0] ST_ODD   = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

	typedef struct packed {
		logic [NODE_W-1:0] owner_node;
		logic [NODE_W-1:0] neighbor_node;
		logic              has_edge;
		logic              last_entry;
	} in_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] cycle_node;
		logic [STAT_W-1:0] status;
		logic              last_result;
	} out_item_t;

	typedef struct packed {
		logic [NODE_W-1:0] owner_node;
		logic [NODE_W-1:0] neighbor_node;
		logic              is_entry;
		logic              is_bad;
		logic              last;
	} cmd_t;

endpackage

[sv/ecf_ram.sv]
// ----------------------------------------------------------------------------
// ecf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ecf_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 33,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/ecf_fifo.sv]
// ----------------------------------------------------------------------------
// ecf_fifo
// Small flop-based queue.
// ----------------------------------------------------------------------------
module ecf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = buf_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			buf_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[sv/ecf_front.sv]
// ----------------------------------------------------------------------------
// ecf_front
// Accepts adjacency entries, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module ecf_front import ecf_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t item,
	output logic     full,
	input  logic     cmd_pop,
	output cmd_t     cmd,
	output logic     cmd_empty
);

	cmd_t cls;
	logic keep;
	logic q_full;

	always_comb begin
		cls.owner_node    = item.owner_node;
		cls.neighbor_node = item.neighbor_node;
		cls.last          = item.last_entry;
		cls.is_bad        = item.has_edge && (item.owner_node == '0
			|| int'(item.owner_node) > MAX_NODES || item.neighbor_node == '0
			|| int'(item.neighbor_node) > MAX_NODES
			|| item.owner_node == item.neighbor_node);
		cls.is_entry      = item.has_edge && !cls.is_bad;
	end

	// drop empty items that do not close the load
	assign keep = item.has_edge || item.last_entry;
	assign full = q_full;

	ecf_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push && keep),
		.wdata (cls),
		.full  (q_full),
		.rd    (cmd_pop),
		.rdata (cmd),
		.empty (cmd_empty)
	);

endmodule

[sv/ecf_back.sv]
// ----------------------------------------------------------------------------
// ecf_back
// Stores adjacency lists, checks the graph and walks the Eulerian circuit.
// ----------------------------------------------------------------------------
module ecf_back import ecf_pkg::*; #(
	parameter int MAX_NODES  = DEF_MAX_NODES,
	parameter int MAX_DEGREE = DEF_MAX_DEGREE,
	parameter int MAX_EDGES  = DEF_MAX_EDGES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [NODE_W-1:0] node_count,
	input  cmd_t              cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	input  logic              out_full,
	output logic              out_push,
	output out_item_t         out_data
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int DW  = $clog2(MAX_DEGREE + 1);
	localparam int KW  = $clog2(MAX_DEGREE);
	localparam int CW  = $clog2(MAX_NODES + 1);
	localparam int PD  = MAX_EDGES + 1;
	localparam int PAW = $clog2(PD);
	localparam int SPW = $clog2(PD + 1);
	localparam int TW  = $clog2(2 * MAX_EDGES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_MROW, S_MPEER, S_XPASS, S_DSWEEP, S_WINIT, S_WFIND,
		S_WPEER, S_WPOP, S_ERD, S_EWR, S_STAT, S_CLR
	} state_t;

	state_t state_q;

	logic [MAX_DEGREE-1:0][NW-1:0] adj_q [MAX_NODES];
	logic [DW-1:0]         deg_q [MAX_NODES];
	logic [MAX_DEGREE-1:0] rm_q  [MAX_NODES];
	logic [MAX_NODES-1:0]  vis_q;
	logic                  bad_q;
	logic [TW-1:0]         total_q;

	logic [NW-1:0]     u_q, v_q, first_q, c_q, nx_q;
	logic [DW-1:0]     k_q, cu_q;
	logic [CW-1:0]     n_q;
	logic              found_q, chg_q, disc_q, odd_q;
	logic [STAT_W-1:0] st_q;
	logic [SPW-1:0]    sp_q, len_q;
	logic [PAW-1:0]    idx_q;

	logic [NODE_W-1:0]     own_m1, nb_m1;
	logic [NW-1:0]         rsel;
	logic [NW-1:0]         row_adj [MAX_DEGREE];
	logic [DW-1:0]         row_deg;
	logic [MAX_DEGREE-1:0] row_rm;
	logic [NW-1:0]         val_sel;
	logic [DW-1:0]         cnt;
	logic                  hit;
	logic [KW-1:0]         hit_k;
	logic [MAX_NODES-1:0]  vis_add;
	logic                  first_hit;
	logic [NW-1:0]         first_nx;
	logic [CW-1:0]         n_clamp;
	logic                  adj_we;
	logic [SPW-1:0]        len_nx;
	logic                  disc_nx, odd_nx;

	logic            st_we, cb_we;
	logic [PAW-1:0]  st_waddr, st_raddr;
	logic [NW-1:0]   st_wdata, st_rdata, cb_rdata;
	logic [SPW-1:0]  sp_m2;

	assign own_m1 = cmd.owner_node - NODE_W'(1);
	assign nb_m1  = cmd.neighbor_node - NODE_W'(1);

	always_comb begin
		unique case (state_q)
			S_IDLE:  rsel = own_m1[NW-1:0];
			S_MPEER: rsel = v_q;
			S_WFIND: rsel = c_q;
			S_WPEER: rsel = nx_q;
			default: rsel = u_q;
		endcase
	end

	always_comb begin
		for (int k = 0; k < MAX_DEGREE; k++) begin
			row_adj[k] = adj_q[rsel][k];
		end
	end
	assign row_deg = deg_q[rsel];
	assign row_rm  = rm_q[rsel];
	assign val_sel = (state_q == S_MPEER) ? u_q : row_adj[k_q[KW-1:0]];

	always_comb begin
		cnt = '0;
		for (int k = 0; k < MAX_DEGREE; k++) begin
			if (DW'(k) < row_deg && row_adj[k] == val_sel) begin
				cnt = cnt + DW'(1);
			end
		end
	end

	always_comb begin
		hit   = 1'b0;
		hit_k = '0;
		for (int k = MAX_DEGREE - 1; k >= 0; k--) begin
			if (DW'(k) < row_deg && !row_rm[k]
				&& (state_q != S_WPEER || row_adj[k] == c_q)) begin
				hit   = 1'b1;
				hit_k = KW'(k);
			end
		end
	end

	always_comb begin
		vis_add = '0;
		if (vis_q[u_q]) begin
			for (int k = 0; k < MAX_DEGREE; k++) begin
				if (DW'(k) < row_deg) begin
					vis_add[row_adj[k]] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (node_count == '0) begin
			n_clamp = CW'(1);
		end else if (int'(node_count) > MAX_NODES) begin
			n_clamp = CW'(MAX_NODES);
		end else begin
			n_clamp = CW'(node_count);
		end
	end

	assign first_hit = !found_q && row_deg != '0 && CW'(u_q) < n_q;
	assign first_nx  = first_hit ? u_q : first_q;
	assign len_nx    = (len_q < SPW'(PD)) ? len_q + SPW'(1) : len_q;
	assign disc_nx   = disc_q || (CW'(u_q) < n_q && row_deg != '0 && !vis_q[u_q]);
	assign odd_nx    = odd_q || (CW'(u_q) < n_q && row_deg[0]);
	assign sp_m2     = sp_q - SPW'(2);

	assign cmd_pop = (state_q == S_IDLE) && !cmd_empty;
	assign adj_we  = cmd_pop && cmd.is_entry && row_deg < DW'(MAX_DEGREE)
		&& total_q < TW'(2 * MAX_EDGES);

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_q[rsel][row_deg[KW-1:0]] <= nb_m1[NW-1:0];
		end
	end

	assign st_we    = (state_q == S_WINIT) || (state_q == S_WPEER && sp_q < SPW'(PD));
	assign st_waddr = (state_q == S_WINIT) ? '0 : sp_q[PAW-1:0];
	assign st_wdata = (state_q == S_WINIT) ? c_q : nx_q;
	assign st_raddr = sp_m2[PAW-1:0];
	assign cb_we    = (state_q == S_WFIND) && !hit && len_q < SPW'(PD);

	ecf_ram #(.WIDTH(NW), .DEPTH(PD)) u_path_stack (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	ecf_ram #(.WIDTH(NW), .DEPTH(PD)) u_cycle_buf (
		.clk  (clk),
		.we   (cb_we),
		.waddr(len_q[PAW-1:0]),
		.wdata(c_q),
		.raddr(idx_q),
		.rdata(cb_rdata)
	);

	assign out_push = (state_q == S_EWR || state_q == S_STAT) && !out_full;

	always_comb begin
		if (state_q == S_STAT) begin
			out_data.cycle_node  = '0;
			out_data.status      = st_q;
			out_data.last_result = 1'b1;
		end else begin
			out_data.cycle_node  = NODE_W'(cb_rdata) + NODE_W'(1);
			out_data.status      = ST_FOUND;
			out_data.last_result = (idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < MAX_NODES; i++) begin
				deg_q[i] <= '0;
				rm_q[i]  <= '0;
			end
			vis_q   <= '0;
			bad_q   <= 1'b0;
			total_q <= '0;
			u_q     <= '0;
			v_q     <= '0;
			first_q <= '0;
			c_q     <= '0;
			nx_q    <= '0;
			k_q     <= '0;
			cu_q    <= '0;
			n_q     <= '0;
			found_q <= 1'b0;
			chg_q   <= 1'b0;
			disc_q  <= 1'b0;
			odd_q   <= 1'b0;
			st_q    <= ST_FOUND;
			sp_q    <= '0;
			len_q   <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						if (cmd.is_bad || (cmd.is_entry && !adj_we)) begin
							bad_q <= 1'b1;
						end
						if (adj_we) begin
							deg_q[rsel] <= row_deg + DW'(1);
							total_q     <= total_q + TW'(1);
						end
						if (cmd.last) begin
							n_q     <= n_clamp;
							u_q     <= '0;
							k_q     <= '0;
							found_q <= 1'b0;
							first_q <= '0;
							state_q <= S_MROW;
						end
					end
				end
				S_MROW: begin
					if (bad_q) begin
						st_q    <= ST_BAD;
						state_q <= S_STAT;
					end else begin
						found_q <= found_q || first_hit;
						first_q <= first_nx;
						if (k_q == row_deg) begin
							k_q <= '0;
							if (u_q == NW'(MAX_NODES - 1)) begin
								u_q   <= '0;
								chg_q <= 1'b0;
								if (found_q || first_hit) begin
									vis_q[first_nx] <= 1'b1;
									state_q         <= S_XPASS;
								end else begin
									c_q     <= '0;
									state_q <= S_WINIT;
								end
							end else begin
								u_q <= u_q + NW'(1);
							end
						end else if (CW'(u_q) >= n_q || CW'(val_sel) >= n_q) begin
							st_q    <= ST_BAD;
							state_q <= S_STAT;
						end else begin
							v_q     <= val_sel;
							cu_q    <= cnt;
							state_q <= S_MPEER;
						end
					end
				end
				S_MPEER: begin
					if (cnt != cu_q) begin
						st_q    <= ST_BAD;
						state_q <= S_STAT;
					end else begin
						k_q     <= k_q + DW'(1);
						state_q <= S_MROW;
					end
				end
				S_XPASS: begin
					vis_q <= vis_q | vis_add;
					chg_q <= chg_q || ((vis_add & ~vis_q) != '0);
					if (u_q == NW'(MAX_NODES - 1)) begin
						u_q   <= '0;
						chg_q <= 1'b0;
						if (!(chg_q || ((vis_add & ~vis_q) != '0))) begin
							disc_q  <= 1'b0;
							odd_q   <= 1'b0;
							state_q <= S_DSWEEP;
						end
					end else begin
						u_q <= u_q + NW'(1);
					end
				end
				S_DSWEEP: begin
					disc_q <= disc_nx;
					odd_q  <= odd_nx;
					if (u_q == NW'(MAX_NODES - 1)) begin
						if (disc_nx) begin
							st_q    <= ST_DISC;
							state_q <= S_STAT;
						end else if (odd_nx) begin
							st_q    <= ST_ODD;
							state_q <= S_STAT;
						end else begin
							c_q     <= first_q;
							state_q <= S_WINIT;
						end
					end else begin
						u_q <= u_q + NW'(1);
					end
				end
				S_WINIT: begin
					sp_q    <= SPW'(1);
					len_q   <= '0;
					state_q <= S_WFIND;
				end
				S_WFIND: begin
					if (hit) begin
						nx_q             <= row_adj[hit_k];
						rm_q[c_q][hit_k] <= 1'b1;
						state_q          <= S_WPEER;
					end else begin
						len_q <= len_nx;
						sp_q  <= sp_q - SPW'(1);
						if (sp_q == SPW'(1)) begin
							if (len_nx == '0) begin
								state_q <= S_CLR;
							end else begin
								idx_q   <= PAW'(len_nx - SPW'(1));
								state_q <= S_ERD;
							end
						end else begin
							state_q <= S_WPOP;
						end
					end
				end
				S_WPOP: begin
					c_q     <= st_rdata;
					state_q <= S_WFIND;
				end
				S_WPEER: begin
					if (hit) begin
						rm_q[nx_q][hit_k] <= 1'b1;
					end
					if (sp_q >= SPW'(PD)) begin
						if (len_q == '0) begin
							state_q <= S_CLR;
						end else begin
							idx_q   <= PAW'(len_q - SPW'(1));
							state_q <= S_ERD;
						end
					end else begin
						sp_q    <= sp_q + SPW'(1);
						c_q     <= nx_q;
						state_q <= S_WFIND;
					end
				end
				S_ERD: begin
					state_q <= S_EWR;
				end
				S_EWR: begin
					if (!out_full) begin
						if (idx_q == '0) begin
							state_q <= S_CLR;
						end else begin
							idx_q   <= idx_q - PAW'(1);
							state_q <= S_ERD;
						end
					end
				end
				S_STAT: begin
					if (!out_full) begin
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					for (int i = 0; i < MAX_NODES; i++) begin
						deg_q[i] <= '0;
						rm_q[i]  <= '0;
					end
					vis_q   <= '0;
					bad_q   <= 1'b0;
					total_q <= '0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/eulerian_cycle_finder_top.sv]
// ----------------------------------------------------------------------------
// eulerian_cycle_finder_top
// Loads an undirected graph entry by entry and emits its Eulerian circuit.
// ----------------------------------------------------------------------------
// Loading: one entry per cycle through a two-entry command queue, while the back end waits in its idle state.
// Search: a check of the stored lists, reachability passes over the nodes,
// and the circuit walk over the edges.
// Circuit nodes are read one at a time from the cycle buffer RAM and pushed out; a full output queue holds them.
// Reset clears all control state and sets node_count to 16; no clearing pass.
module eulerian_cycle_finder_top import ecf_pkg::*; #(
	parameter int MAX_NODES  = DEF_MAX_NODES,
	parameter int MAX_DEGREE = DEF_MAX_DEGREE,
	parameter int MAX_EDGES  = DEF_MAX_EDGES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  in_item_t          item,
	output logic              empty,
	input  logic              pop,
	output out_item_t         result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [NODE_W-1:0] cfg_data
);

	logic [NODE_W-1:0] node_count_q;
	cmd_t              cmd;
	logic              cmd_empty;
	logic              cmd_pop;
	logic              out_full;
	logic              out_push;
	out_item_t         out_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= DEF_NODE_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	ecf_front #(.MAX_NODES(MAX_NODES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_empty(cmd_empty)
	);

	ecf_back #(
		.MAX_NODES (MAX_NODES),
		.MAX_DEGREE(MAX_DEGREE),
		.MAX_EDGES (MAX_EDGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.node_count(node_count_q),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_data)
	);

	ecf_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(2)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (out_push),
		.wdata (out_data),
		.full  (out_full),
		.rd    (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the Eulerian circuit finder. Graphs are loaded entry by entry
// through the push side. A behavioral copy of the loader and of the circuit
// search predicts every result, and each popped result is compared field by
// field. The stimulus covers directed corner graphs, random Eulerian graphs,
// broken graphs and noise, under several node_count settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import ecf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES  = DEF_MAX_NODES;
	localparam int DEGREE = DEF_MAX_DEGREE;
	localparam int EDGES  = DEF_MAX_EDGES;
	localparam int DEPTH  = NODES * DEGREE;
	localparam int PATH   = EDGES + 1;
	localparam int SETTLE = 600;
	localparam int LIMIT  = 1000000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	in_item_t          item = '0;
	logic              empty;
	logic              pop = 1'b0;
	out_item_t         result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [NODE_W-1:0] cfg_data = '0;

	eulerian_cycle_finder_top DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predicted graph state
	logic [3:0]        adj [DEPTH];
	logic              removed [DEPTH];
	int                degree_of [NODES];
	logic              seen [NODES];
	logic [3:0]        walk [PATH];
	logic [3:0]        circuit [PATH];
	logic              malformed;
	int                stored;
	logic [NODE_W-1:0] node_count_reg = DEF_NODE_COUNT;

	out_item_t circuit_q[$];
	int        errors = 0;
	int        send_idle = 0;
	int        recv_idle = 0;
	int        cycles = 0;

	function automatic int count_in(int u, int v);
		int c = 0;
		for (int k = 0; k < degree_of[u]; k++)
			if (int'(adj[u*DEGREE+k]) == v) c++;
		return c;
	endfunction

	task automatic clear_graph();
		for (int i = 0; i < DEPTH; i++) begin
			adj[i] = '0;
			removed[i] = 1'b0;
		end
		for (int i = 0; i < NODES; i++) begin
			degree_of[i] = 0;
			seen[i] = 1'b0;
		end
		malformed = 1'b0;
		stored = 0;
	endtask

	task automatic check_graph(input int n, output logic [STAT_W-1:0] st, output int start);
		int first;
		int sp;
		int u;
		int v;
		int stk [NODES];
		first = NODES;
		start = 0;
		if (malformed) begin
			st = ST_BAD;
			return;
		end
		for (u = 0; u < NODES; u++)
			for (int k = 0; k < degree_of[u]; k++) begin
				v = int'(adj[u*DEGREE+k]);
				if (u >= n || v >= n || count_in(u, v) != count_in(v, u)) begin
					st = ST_BAD;
					return;
				end
			end
		for (u = 0; u < n; u++)
			if (degree_of[u] != 0 && first == NODES) first = u;
		st = ST_FOUND;
		if (first == NODES) return;
		start = first;
		for (u = 0; u < NODES; u++) seen[u] = 1'b0;
		sp = 0;
		seen[first] = 1'b1;
		stk[sp] = first;
		sp = sp + 1;
		while (sp > 0) begin
			sp = sp - 1;
			u = stk[sp];
			for (int k = 0; k < degree_of[u]; k++) begin
				v = int'(adj[u*DEGREE+k]);
				if (!seen[v] && sp < NODES) begin
					seen[v] = 1'b1;
					stk[sp] = v;
					sp = sp + 1;
				end
			end
		end
		for (u = 0; u < n; u++)
			if (degree_of[u] != 0 && !seen[u]) begin
				st = ST_DISC;
				return;
			end
		for (u = 0; u < n; u++)
			if (degree_of[u] % 2 == 1) begin
				st = ST_ODD;
				return;
			end
	endtask

	task automatic trace_circuit();
		int n;
		int start;
		int sp;
		int len;
		int c;
		int k;
		int nx;
		logic [STAT_W-1:0] st;
		out_item_t r;
		n = int'(node_count_reg);
		if (n < 1) n = 1;
		if (n > NODES) n = NODES;
		check_graph(n, st, start);
		if (st != ST_FOUND) begin
			r.cycle_node = '0;
			r.status = st;
			r.last_result = 1'b1;
			circuit_q.insert(circuit_q.size(), r);
			return;
		end
		sp = 0;
		len = 0;
		walk[sp] = 4'(start);
		sp = sp + 1;
		while (sp > 0) begin
			c = int'(walk[sp-1]);
			for (k = 0; k < degree_of[c]; k++)
				if (!removed[c*DEGREE+k]) break;
			if (k < degree_of[c]) begin
				nx = int'(adj[c*DEGREE+k]);
				removed[c*DEGREE+k] = 1'b1;
				for (int i = 0; i < degree_of[nx]; i++)
					if (!removed[nx*DEGREE+i] && int'(adj[nx*DEGREE+i]) == c) begin
						removed[nx*DEGREE+i] = 1'b1;
						break;
					end
				if (sp >= PATH) break;
				walk[sp] = 4'(nx);
				sp = sp + 1;
			end else begin
				if (len < PATH) begin
					circuit[len] = 4'(c);
					len = len + 1;
				end
				sp--;
			end
		end
		for (int i = 0; i < len; i++) begin
			r.cycle_node = NODE_W'(circuit[len-1-i]) + NODE_W'(1);
			r.status = ST_FOUND;
			r.last_result = (i == len - 1);
			circuit_q.insert(circuit_q.size(), r);
		end
	endtask

	task automatic load_entry(input in_item_t it);
		int o;
		int nb;
		o = int'(it.owner_node);
		nb = int'(it.neighbor_node);
		if (it.has_edge) begin
			if (o < 1 || o > NODES || nb < 1 || nb > NODES || o == nb)
				malformed = 1'b1;
			else if (degree_of[o-1] >= DEGREE || stored >= 2 * EDGES)
				malformed = 1'b1;
			else begin
				adj[(o-1)*DEGREE+degree_of[o-1]] = 4'(nb - 1);
				degree_of[o-1]++;
				stored++;
			end
		end
		if (it.last_entry) begin
			trace_circuit();
			clear_graph();
		end
	endtask

	task automatic send_entry(input int o, input int nb, input bit has, input bit last);
		in_item_t it;
		it.owner_node = NODE_W'(o);
		it.neighbor_node = NODE_W'(nb);
		it.has_edge = has;
		it.last_entry = last;
		if ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		load_entry(it);
	endtask

	task automatic send_edge(input int u, input int v, input bit last);
		send_entry(u, v, 1'b1, 1'b0);
		send_entry(v, u, 1'b1, last);
	endtask

	task automatic write_node_count(input logic [NODE_W-1:0] v);
		push <= 1'b0;
		while (circuit_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		node_count_reg = v;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (pop && !empty) begin
			if (circuit_q.size() == 0) begin
				$error("result with nothing expected: %p", result);
				errors++;
			end else begin
				want = circuit_q.pop_front();
				if (result.cycle_node !== want.cycle_node) begin
					$error("cycle_node expected %0d got %0d", want.cycle_node,
						result.cycle_node);
					errors++;
				end
				if (result.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, result.status);
					errors++;
				end
				if (result.last_result !== want.last_result) begin
					$error("last_result expected %0d got %0d", want.last_result,
						result.last_result);
					errors++;
				end
			end
		end
		pop <= ($urandom_range(99) >= recv_idle);
	end

	task automatic test_directed();
		// edge-free graph
		send_entry(0, 0, 1'b0, 1'b1);
		// triangle from node 1
		send_edge(1, 2, 1'b0);
		send_edge(2, 3, 1'b0);
		send_edge(3, 1, 1'b1);
		// one-sided entry
		send_entry(1, 2, 1'b1, 1'b1);
		// out of range and self loop
		send_entry(0, 2, 1'b1, 1'b1);
		send_entry(31, 31, 1'b1, 1'b0);
		send_entry(4, 4, 1'b1, 1'b1);
		// overfull list
		for (int i = 2; i <= 6; i++) send_entry(1, i, 1'b1, i == 6);
		// two separate double edges, start away from node 1
		send_edge(2, 3, 1'b0);
		send_edge(3, 2, 1'b0);
		send_edge(16, 15, 1'b0);
		send_edge(15, 16, 1'b1);
		// single edge: odd degrees
		send_edge(1, 16, 1'b1);
		// nodes beyond node_count
		write_node_count(5'd3);
		send_edge(3, 4, 1'b0);
		send_edge(4, 3, 1'b1);
	endtask

	task automatic send_graph(input int n);
		int deg [NODES+1];
		int ord [NODES];
		int ent [$];
		int len;
		int t;
		int j;
		int mode;
		for (int i = 0; i <= NODES; i++) deg[i] = 0;
		repeat ($urandom_range(1, 4)) begin
			for (int i = 0; i < n; i++) ord[i] = i + 1;
			for (int i = n - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = ord[i]; ord[i] = ord[j]; ord[j] = t;
			end
			len = (n < 3) ? 2 : $urandom_range(3, (n < 6) ? n : 6);
			t = 1;
			for (int i = 0; i < len; i++) if (deg[ord[i]] > DEGREE - 2) t = 0;
			if (t) begin
				for (int i = 0; i < len; i++) begin
					ent.insert(ent.size(), ord[i] * 32 + ord[(i+1)%len]);
					ent.insert(ent.size(), ord[(i+1)%len] * 32 + ord[i]);
					deg[ord[i]] += 2;
				end
			end
		end
		mode = $urandom_range(0, 9);
		if (mode == 0 && ent.size() > 0) ent.pop_back();
		if (mode == 1)
			ent.insert(ent.size(), $urandom_range(0, 31) * 32 + $urandom_range(0, 31));
		if (mode == 2) begin
			ent.insert(ent.size(), 1 * 32 + n);
			ent.insert(ent.size(), n * 32 + 1);
		end
		for (int i = ent.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = ent[i]; ent[i] = ent[j]; ent[j] = t;
		end
		foreach (ent[i]) begin
			if ($urandom_range(9) == 0)
				send_entry($urandom_range(0, 31), $urandom_range(0, 31), 1'b0, 1'b0);
			send_entry(ent[i] / 32, ent[i] % 32, 1'b1, 1'b0);
		end
		send_entry($urandom_range(0, 31), $urandom_range(0, 31), 1'b0, 1'b1);
	endtask

	task automatic test_random(input int graphs);
		int n;
		repeat (graphs) begin
			n = int'(node_count_reg);
			if (n < 1) n = 1;
			if (n > NODES) n = NODES;
			if (n < 2 || $urandom_range(4) == 0) begin
				repeat ($urandom_range(1, 6))
					send_entry($urandom_range(0, 31), $urandom_range(0, 31),
						$urandom_range(0, 1), 1'b0);
				send_entry(1, 2, 1'b0, 1'b1);
			end else begin
				send_graph(n);
			end
		end
	endtask

	initial begin
		clear_graph();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 7;
		recv_idle = 56;
		test_directed();
		write_node_count(5'd16);
		test_random(3);
		write_node_count(5'd0);
		test_random(2);
		send_idle = 56;
		recv_idle = 7;
		write_node_count(5'd31);
		test_random(3);
		write_node_count(5'd2);
		test_random(3);
		send_idle = 0;
		recv_idle = 0;
		write_node_count(5'd1);
		test_random(2);
		write_node_count(5'($urandom_range(4, 15)));
		test_random(2);
		write_node_count(5'd16);
		test_random(3);
		push <= 1'b0;
		while (circuit_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
